// ===== src/bitmap_frame_allocator_macros.svh =====
// Assertion macros used by the frame allocator top level.
`ifndef BITMAP_FRAME_ALLOCATOR_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
// Check cons in the same cycle as ante; expects clk and rst_n in scope.
`define BFA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame allocator check failed");
// Check cons in the cycle after ante.
`define BFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame allocator check failed");
`else
`define BFA_ASSERT_NOW(lbl, ante, cons)
`define BFA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/bfa_pkg.sv =====
// Shared types and constants of the bitmap frame allocator.
package bfa_pkg;

  localparam int WORD_BITS = 64;
  localparam int CNT_W     = 16;
  localparam int FADDR_W   = 27;
  localparam int TOTAL_RST = 32768;

  typedef logic [1:0] req_t;
  localparam req_t REQ_ALLOC       = 2'd0;
  localparam req_t REQ_FREE        = 2'd1;
  localparam req_t REQ_RESERVE     = 2'd2;
  localparam req_t REQ_FREE_REGION = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_RANGE,
    ST_WALK,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    WOP_SCAN,
    WOP_SET,
    WOP_CLEAR
  } wop_mode_t;

  // Control for one bitmap word: bit range lo..hi (scan treats bits above hi as used)
  typedef struct packed {
    wop_mode_t  mode;
    logic [5:0] lo;
    logic [5:0] hi;
  } wop_ctl_t;

  typedef struct packed {
    logic       found;
    logic [5:0] pos;
  } wop_res_t;

endpackage

// ===== src/bfa_if.sv =====
// Request and result channel interfaces of the frame allocator.
interface bfa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] addr;
  logic [31:0] region_bytes;

  modport source (output valid, req_type, addr, region_bytes, input ready);
  modport sink (input valid, req_type, addr, region_bytes, output ready);
endinterface

interface bfa_res_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [26:0] frame_addr;
  logic [15:0] used_count;
  logic [15:0] usable_count;
  logic [15:0] reserved_count;

  modport source (output valid, status, frame_addr, used_count, usable_count,
                  reserved_count, input ready);
  modport sink (input valid, status, frame_addr, used_count, usable_count,
                reserved_count, output ready);
endinterface

// ===== src/bfa_ram.sv =====
// Generic simple dual-port RAM with registered read.
module bfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/bfa_word_op.sv =====
// Modify one bitmap word: set or clear a bit range, or find and set the lowest free bit.
module bfa_word_op (
  input  bfa_pkg::wop_ctl_t ctl,
  input  logic [63:0]       data_in,
  output logic [63:0]       data_out,
  output bfa_pkg::wop_res_t res
);

  logic [63:0] range_m;
  logic [63:0] busy;

  // Build range mask; bits above hi count as used for the scan
  always_comb begin
    for (int b = 0; b < 64; b++) begin
      range_m[b] = (6'(b) >= ctl.lo) && (6'(b) <= ctl.hi);
      busy[b]    = data_in[b] | (6'(b) > ctl.hi);
    end
  end

  // Find lowest free bit and produce the new word
  always_comb begin
    res.found = 1'b0;
    res.pos   = '0;
    for (int b = 63; b >= 0; b--) begin
      if (!busy[b]) begin
        res.found = 1'b1;
        res.pos   = 6'(b);
      end
    end
    case (ctl.mode)
      bfa_pkg::WOP_SCAN:  data_out = data_in | (res.found ? (64'd1 << res.pos) : 64'd0);
      bfa_pkg::WOP_SET:   data_out = data_in | range_m;
      bfa_pkg::WOP_CLEAR: data_out = data_in & ~range_m;
      default:            data_out = data_in;
    endcase
  end

endmodule

// ===== src/bitmap_frame_allocator.sv =====
// Top level of the bitmap frame allocator: request sequencer, counters and result register.
//
//   channel   dir  handshake        payload
//   in_req    in   valid/ready      req_type, addr, region_bytes
//   out_res   out  valid/ready      status, frame_addr, used/usable/reserved_count
//   cfg       in   cfg_wr_en        cfg_wr_data (total_frames)
//
// After reset a clearing pass writes every bitmap word to all ones, one word a
// cycle; no request is taken meanwhile. Free and region requests pass through the
// decode and range states, then walk each bitmap word covered (none if out of the map).
// Allocate scans up from word 0 to the first free bit within min(total_frames, FRAME_COUNT).
// One request is in work at a time; the bitmap RAM read port sets the pace.
// A finished result waits in the output register while the next request is taken.
`include "bitmap_frame_allocator_macros.svh"

module bitmap_frame_allocator #(
  parameter int FRAME_COUNT = 32768,
  parameter int FRAME_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  bfa_req_if.sink     in_req,
  bfa_res_if.source   out_res,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int WORDS = (FRAME_COUNT + 63) / 64;
  localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int XW    = WAW + 6;
  localparam int NW    = XW + 1;
  localparam int LW    = (NW > 16) ? NW : 16;
  localparam int SW    = LW + 1;
  localparam int FBW   = $clog2(FRAME_BYTES);

  bfa_pkg::state_t state_r, state_nxt;
  logic [WAW-1:0]  word_r, word_nxt;
  logic [1:0]      type_r, type_nxt;
  logic [31:0]     addr_r, addr_nxt;
  logic [31:0]     bytes_r, bytes_nxt;
  logic [32:0]     first_r, first_nxt;
  logic [31:0]     cnt_r, cnt_nxt;
  logic [WAW-1:0]  fw_r, fw_nxt;
  logic [WAW-1:0]  lw_r, lw_nxt;
  logic [5:0]      lo_r, lo_nxt;
  logic [5:0]      hi_r, hi_nxt;
  logic            status_r, status_nxt;
  logic [26:0]     faddr_r, faddr_nxt;
  logic [15:0]     used_r, used_nxt;
  logic [15:0]     usable_r, usable_nxt;
  logic [15:0]     reserved_r, reserved_nxt;
  logic [15:0]     total_r;
  logic            out_valid_r, out_valid_nxt;
  logic            out_status_r;
  logic [26:0]     out_faddr_r;
  logic [15:0]     out_used_r, out_usable_r, out_reserved_r;

  logic            wr_en;
  logic [63:0]     wr_data;
  logic [63:0]     wop_data;
  logic [63:0]     rd_data;
  bfa_pkg::wop_ctl_t wop_ctl;
  bfa_pkg::wop_res_t wop_res;

  logic            accept;
  logic            out_free;
  logic            is_alloc;
  logic            last_word;
  logic            walk_done;
  logic [LW-1:0]   limit;
  logic            can_alloc;
  logic [XW-1:0]   last_idx;
  logic [33:0]     end_full;
  logic [33:0]     end_clip;
  logic            in_map;
  logic [NW-1:0]   n_frames;
  logic [XW-1:0]   first_idx;
  logic [XW-1:0]   end_idx;
  logic [31:0]     cnt_raw;
  logic [XW-1:0]   found_idx;

  function automatic logic [15:0] sat_add(input logic [15:0] c, input logic [NW-1:0] n);
    logic [SW-1:0] s;
    s = SW'(c) + SW'(n);
    return (s > SW'(16'hFFFF)) ? 16'hFFFF : s[15:0];
  endfunction

  // Bitmap storage
  bfa_ram #(
    .WIDTH(64),
    .DEPTH(WORDS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(word_r),
    .wr_data(wr_data),
    .rd_addr(word_nxt),
    .rd_data(rd_data)
  );

  // Per-word modify unit
  bfa_word_op u_word_op (
    .ctl     (wop_ctl),
    .data_in (rd_data),
    .data_out(wop_data),
    .res     (wop_res)
  );

  // Fill with all ones during the clearing pass, else write the modified word
  assign wr_data = (state_r == bfa_pkg::ST_CLEAR) ? ~64'd0 : wop_data;

  // Handshake and decode helpers
  assign accept       = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == bfa_pkg::ST_IDLE);
  assign out_free     = !out_valid_r || out_res.ready;
  assign is_alloc     = (type_r == bfa_pkg::REQ_ALLOC);
  assign last_word    = (word_r == lw_r);
  assign walk_done    = last_word || (is_alloc && wop_res.found);

  assign limit     = (LW'(total_r) < LW'(FRAME_COUNT)) ? LW'(total_r) : LW'(FRAME_COUNT);
  assign can_alloc = (limit != '0) && (usable_r > used_r);
  assign last_idx  = XW'(limit - LW'(1));
  assign cnt_raw   = bytes_r >> FBW;

  assign end_full  = 34'(first_r) + 34'(cnt_r);
  assign in_map    = first_r < 33'(FRAME_COUNT);
  assign end_clip  = (end_full > 34'(FRAME_COUNT)) ? 34'(FRAME_COUNT) : end_full;
  assign n_frames  = NW'(end_clip - 34'(first_r));
  assign first_idx = XW'(first_r);
  assign end_idx   = XW'(end_clip - 34'd1);
  assign found_idx = {word_r, wop_res.pos};

  // Word operation for the current walk step
  always_comb begin
    case (type_r)
      bfa_pkg::REQ_ALLOC:   wop_ctl.mode = bfa_pkg::WOP_SCAN;
      bfa_pkg::REQ_RESERVE: wop_ctl.mode = bfa_pkg::WOP_SET;
      default:              wop_ctl.mode = bfa_pkg::WOP_CLEAR;
    endcase
    wop_ctl.lo = (word_r == fw_r) ? lo_r : 6'd0;
    wop_ctl.hi = last_word ? hi_r : 6'd63;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bfa_pkg::ST_CLEAR:  if (word_r == WAW'(WORDS - 1)) state_nxt = bfa_pkg::ST_IDLE;
      bfa_pkg::ST_IDLE:   if (accept) state_nxt = bfa_pkg::ST_DECODE;
      bfa_pkg::ST_DECODE: begin
        if (!is_alloc) state_nxt = bfa_pkg::ST_RANGE;
        else if (can_alloc) state_nxt = bfa_pkg::ST_WALK;
        else state_nxt = bfa_pkg::ST_FINISH;
      end
      bfa_pkg::ST_RANGE:  state_nxt = in_map ? bfa_pkg::ST_WALK : bfa_pkg::ST_FINISH;
      bfa_pkg::ST_WALK:   if (walk_done) state_nxt = bfa_pkg::ST_FINISH;
      bfa_pkg::ST_FINISH: if (out_free) state_nxt = bfa_pkg::ST_IDLE;
      default:            state_nxt = bfa_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    word_nxt      = word_r;
    type_nxt      = type_r;
    addr_nxt      = addr_r;
    bytes_nxt     = bytes_r;
    first_nxt     = first_r;
    cnt_nxt       = cnt_r;
    fw_nxt        = fw_r;
    lw_nxt        = lw_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    status_nxt    = status_r;
    faddr_nxt     = faddr_r;
    used_nxt      = used_r;
    usable_nxt    = usable_r;
    reserved_nxt  = reserved_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    wr_en         = 1'b0;
    case (state_r)
      bfa_pkg::ST_CLEAR: begin
        wr_en    = 1'b1;
        word_nxt = word_r + WAW'(1);
      end
      bfa_pkg::ST_IDLE: begin
        if (accept) begin
          type_nxt   = in_req.req_type;
          addr_nxt   = in_req.addr;
          bytes_nxt  = in_req.region_bytes;
          status_nxt = 1'b0;
          faddr_nxt  = '0;
        end
      end
      bfa_pkg::ST_DECODE: begin
        if (is_alloc) begin
          status_nxt = !can_alloc;
          word_nxt   = '0;
          fw_nxt     = '0;
          lo_nxt     = 6'd0;
          lw_nxt     = last_idx[XW-1:6];
          hi_nxt     = last_idx[5:0];
        end else if (type_r == bfa_pkg::REQ_FREE) begin
          first_nxt = 33'(addr_r >> FBW);
          cnt_nxt   = 32'd1;
        end else begin
          first_nxt = 33'((34'(addr_r) + 34'(FRAME_BYTES - 1)) >> FBW);
          cnt_nxt   = (cnt_raw == 32'd0) ? 32'd1 : cnt_raw;
        end
      end
      bfa_pkg::ST_RANGE: begin
        fw_nxt   = first_idx[XW-1:6];
        lo_nxt   = first_idx[5:0];
        lw_nxt   = end_idx[XW-1:6];
        hi_nxt   = end_idx[5:0];
        word_nxt = first_idx[XW-1:6];
        if (in_map) begin
          case (type_r)
            bfa_pkg::REQ_FREE:    used_nxt = (used_r == 16'd0) ? 16'd0 : used_r - 16'd1;
            bfa_pkg::REQ_RESERVE: begin
              reserved_nxt = sat_add(reserved_r, n_frames);
              used_nxt     = sat_add(used_r, n_frames);
            end
            bfa_pkg::REQ_FREE_REGION: usable_nxt = sat_add(usable_r, n_frames);
            default: ;
          endcase
        end
      end
      bfa_pkg::ST_WALK: begin
        wr_en = !is_alloc || wop_res.found;
        if (is_alloc && wop_res.found) begin
          used_nxt  = sat_add(used_r, NW'(1));
          faddr_nxt = 27'(64'(found_idx) << FBW);
        end else if (is_alloc && last_word) begin
          status_nxt = 1'b1;
        end
        if (!walk_done) word_nxt = word_r + WAW'(1);
      end
      bfa_pkg::ST_FINISH: begin
        if (out_free) out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfa_pkg::ST_CLEAR;
      word_r      <= '0;
      used_r      <= '0;
      usable_r    <= '0;
      reserved_r  <= '0;
      total_r     <= 16'(bfa_pkg::TOTAL_RST);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      word_r      <= word_nxt;
      used_r      <= used_nxt;
      usable_r    <= usable_nxt;
      reserved_r  <= reserved_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) total_r <= cfg_wr_data;
    end
  end

  // Request payload and result registers
  always_ff @(posedge clk) begin
    type_r   <= type_nxt;
    addr_r   <= addr_nxt;
    bytes_r  <= bytes_nxt;
    first_r  <= first_nxt;
    cnt_r    <= cnt_nxt;
    fw_r     <= fw_nxt;
    lw_r     <= lw_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    status_r <= status_nxt;
    faddr_r  <= faddr_nxt;
    if (state_r == bfa_pkg::ST_FINISH && out_free) begin
      out_status_r   <= status_r;
      out_faddr_r    <= faddr_r;
      out_used_r     <= used_r;
      out_usable_r   <= usable_r;
      out_reserved_r <= reserved_r;
    end
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.status         = out_status_r;
  assign out_res.frame_addr     = out_faddr_r;
  assign out_res.used_count     = out_used_r;
  assign out_res.usable_count   = out_usable_r;
  assign out_res.reserved_count = out_reserved_r;

  // Checks
  `BFA_ASSERT_NEXT(a_accept_decode, accept, state_r == bfa_pkg::ST_DECODE)
  `BFA_ASSERT_NOW(a_result_from_finish, $rose(out_valid_r), $past(state_r == bfa_pkg::ST_FINISH))
  `BFA_ASSERT_NOW(a_alloc_sets_one, wr_en && state_r == bfa_pkg::ST_WALK && is_alloc, $countones(wr_data) == $countones(rd_data) + 1)
  `BFA_ASSERT_NOW(a_fail_only_alloc, state_r == bfa_pkg::ST_FINISH && status_r, is_alloc)

endmodule

// ===== dv/bitmap_frame_allocator_tb.sv =====
// Self-checking testbench for the bitmap frame allocator: directed and random requests.
module bitmap_frame_allocator_tb;

  localparam int NFRAMES  = 32768;
  localparam int PAGE     = 4096;
  localparam int CNT_SAT  = 65535;

  typedef struct {
    logic        status;
    logic [26:0] frame_addr;
    logic [15:0] used_count;
    logic [15:0] usable_count;
    logic [15:0] reserved_count;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  bfa_req_if req_ch ();
  bfa_res_if res_ch ();

  bitmap_frame_allocator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (req_ch.sink),
    .out_res    (res_ch.source),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  // Shadow of the allocator state
  bit            frame_used[NFRAMES];
  int unsigned   usable_cnt, used_cnt, reserved_cnt;
  int unsigned   search_limit_cfg;
  alloc_result_t expected_q[$];
  logic [31:0]   granted_q[$];
  int            fail_cnt;
  int            req_cnt, res_cnt, grant_cnt, refuse_cnt;
  bit            calm;

  function automatic int unsigned sat_add(int unsigned c, longint unsigned n);
    longint unsigned s;
    s = c + n;
    return (s > CNT_SAT) ? CNT_SAT : int'(s);
  endfunction

  // Apply one request to the shadow state and return the expected result
  function automatic alloc_result_t model_request(bfa_pkg::req_t kind, logic [31:0] addr,
                                                  logic [31:0] nbytes);
    alloc_result_t   r;
    longint unsigned first, cnt, last, n, lim;
    int              hit;
    r.status = 1'b0;
    r.frame_addr = '0;
    hit = -1;
    case (kind)
      bfa_pkg::REQ_ALLOC: begin
        lim = (search_limit_cfg < NFRAMES) ? search_limit_cfg : NFRAMES;
        if (usable_cnt > used_cnt) begin
          for (int i = 0; i < lim; i++) begin
            if (!frame_used[i]) begin
              hit = i;
              break;
            end
          end
        end
        if (hit >= 0) begin
          frame_used[hit] = 1'b1;
          used_cnt = sat_add(used_cnt, 1);
          r.frame_addr = 27'(longint'(hit) * PAGE);
          granted_q.push_back(32'(longint'(hit) * PAGE));
          grant_cnt++;
        end else begin
          r.status = 1'b1;
          refuse_cnt++;
        end
      end
      bfa_pkg::REQ_FREE: begin
        if (addr / PAGE < NFRAMES) begin
          frame_used[addr / PAGE] = 1'b0;
          used_cnt = (used_cnt == 0) ? 0 : used_cnt - 1;
        end
      end
      default: begin
        first = (longint'(addr) + PAGE - 1) / PAGE;
        cnt = (nbytes < PAGE) ? 1 : nbytes / PAGE;
        last = first + cnt;
        if (last > NFRAMES) last = NFRAMES;
        n = (last > first) ? last - first : 0;
        for (longint unsigned i = 0; i < n; i++)
          frame_used[first + i] = (kind == bfa_pkg::REQ_RESERVE);
        if (kind == bfa_pkg::REQ_RESERVE) begin
          reserved_cnt = sat_add(reserved_cnt, n);
          used_cnt = sat_add(used_cnt, n);
        end else begin
          usable_cnt = sat_add(usable_cnt, n);
        end
      end
    endcase
    r.used_count = used_cnt[15:0];
    r.usable_count = usable_cnt[15:0];
    r.reserved_count = reserved_cnt[15:0];
    return r;
  endfunction

  // Send one request with a random lead-in gap; predict at acceptance
  task automatic send_req(bfa_pkg::req_t kind, logic [31:0] addr, logic [31:0] nbytes);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.addr <= addr;
    req_ch.region_bytes <= nbytes;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    expected_q.push_back(model_request(kind, addr, nbytes));
    req_cnt++;
  endtask

  // Hold off new requests until every result is back
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_total(logic [15:0] value);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    search_limit_cfg = value;
  endtask

  // Result sink with random stalls; check each accepted result
  initial begin
    alloc_result_t e;
    int stall;
    res_ch.ready = 1'b0;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid === 1'b1 && res_ch.ready === 1'b1));
      res_cnt++;
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding");
        fail_cnt++;
      end else begin
        e = expected_q.pop_front();
        if (res_ch.status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, res_ch.status);
          fail_cnt++;
        end
        if (res_ch.frame_addr !== e.frame_addr) begin
          $error("frame_addr: expected %h actual %h", e.frame_addr, res_ch.frame_addr);
          fail_cnt++;
        end
        if (res_ch.used_count !== e.used_count) begin
          $error("used_count: expected %0d actual %0d", e.used_count, res_ch.used_count);
          fail_cnt++;
        end
        if (res_ch.usable_count !== e.usable_count) begin
          $error("usable_count: expected %0d actual %0d", e.usable_count,
                 res_ch.usable_count);
          fail_cnt++;
        end
        if (res_ch.reserved_count !== e.reserved_count) begin
          $error("reserved_count: expected %0d actual %0d", e.reserved_count,
                 res_ch.reserved_count);
          fail_cnt++;
        end
      end
    end
  end

  // Empty map refuses; then open one frame and cycle it
  task automatic test_empty_and_first_frame();
    send_req(bfa_pkg::REQ_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(bfa_pkg::REQ_FREE, 32'd0, 32'd0);
    send_req(bfa_pkg::REQ_FREE_REGION, 32'd0, 32'd0);
    send_req(bfa_pkg::REQ_ALLOC, 32'd0, 32'd0);
    send_req(bfa_pkg::REQ_ALLOC, 32'd0, 32'd0);
    send_req(bfa_pkg::REQ_FREE, 32'd123, 32'd0);
    send_req(bfa_pkg::REQ_ALLOC, 32'd0, 32'd0);
  endtask

  // Region rounding, out-of-map frames and counter saturation
  task automatic test_region_edges();
    send_req(bfa_pkg::REQ_FREE_REGION, 32'd1, 32'd4095);
    send_req(bfa_pkg::REQ_FREE_REGION, 32'd4097, 32'd12288);
    send_req(bfa_pkg::REQ_RESERVE, 32'd8192, 32'd8191);
    send_req(bfa_pkg::REQ_FREE, 32'h0800_0000, 32'd0);
    send_req(bfa_pkg::REQ_FREE_REGION, 32'hFFFF_F001, 32'hFFFF_FFFF);
    send_req(bfa_pkg::REQ_FREE_REGION, 32'h07FF_F000, 32'd8192);
    send_req(bfa_pkg::REQ_FREE_REGION, 32'd0, 32'hFFFF_FFFF);
    send_req(bfa_pkg::REQ_FREE_REGION, 32'd0, 32'hFFFF_FFFF);
    send_req(bfa_pkg::REQ_RESERVE, 32'd0, 32'hFFFF_FFFF);
    send_req(bfa_pkg::REQ_RESERVE, 32'd0, 32'hFFFF_FFFF);
    send_req(bfa_pkg::REQ_ALLOC, 32'd0, 32'd0);
    send_req(bfa_pkg::REQ_FREE_REGION, 32'd0, 32'hFFFF_FFFF);
    repeat (3) send_req(bfa_pkg::REQ_ALLOC, 32'd0, 32'd0);
  endtask

  // Search limit extremes, including zero
  task automatic test_search_limits();
    write_total(16'd0);
    send_req(bfa_pkg::REQ_ALLOC, 32'd0, 32'd0);
    write_total(16'd1);
    send_req(bfa_pkg::REQ_ALLOC, 32'd0, 32'd0);
    send_req(bfa_pkg::REQ_ALLOC, 32'd0, 32'd0);
    write_total(16'hFFFF);
    send_req(bfa_pkg::REQ_ALLOC, 32'd0, 32'd0);
  endtask

  // Random mix: mostly small regions near the bottom and frees of granted frames
  task automatic test_random_mix(int count);
    int          pick;
    logic [31:0] a, b;
    for (int k = 0; k < count; k++) begin
      if (k % 200 == 0) begin
        case ($urandom_range(0, 5))
          0: write_total(16'd0);
          1: write_total(16'($urandom_range(1, 64)));
          2: write_total(16'($urandom_range(65, 2048)));
          3: write_total(16'(NFRAMES));
          4: write_total(16'hFFFF);
          default: write_total(16'($urandom));
        endcase
        calm = ($urandom_range(0, 2) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_req(bfa_pkg::REQ_ALLOC, $urandom, $urandom);
      end else if (pick < 60) begin
        if (granted_q.size() != 0 && $urandom_range(0, 3) != 0) begin
          a = granted_q[$urandom_range(0, granted_q.size() - 1)] + $urandom_range(0, PAGE - 1);
        end else begin
          a = $urandom;
        end
        send_req(bfa_pkg::REQ_FREE, a, $urandom);
      end else begin
        if (pick < 95) begin
          a = $urandom_range(0, 300 * PAGE);
          b = $urandom_range(0, 16 * PAGE);
        end else begin
          a = $urandom;
          b = $urandom;
        end
        send_req((pick % 3 == 0) ? bfa_pkg::REQ_RESERVE : bfa_pkg::REQ_FREE_REGION, a, b);
      end
    end
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = bfa_pkg::REQ_ALLOC;
    req_ch.addr = '0;
    req_ch.region_bytes = '0;
    fail_cnt = 0;
    calm = 1'b0;
    for (int i = 0; i < NFRAMES; i++) frame_used[i] = 1'b1;
    usable_cnt = 0;
    used_cnt = 0;
    reserved_cnt = 0;
    search_limit_cfg = bfa_pkg::TOTAL_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_and_first_frame();
    test_region_edges();
    test_search_limits();
    write_total(16'(NFRAMES));
    test_random_mix(1130);

    drain();
    repeat (600) @(posedge clk);
    $display("Covered %0d requests, %0d results: %0d frames granted, %0d refused,",
             req_cnt, res_cnt, grant_cnt, refuse_cnt);
    $display("across several search limits from zero to the full register range.");
    if (fail_cnt == 0 && expected_q.size() == 0) begin
      $display("** bitmap_frame_allocator: PASSED **");
    end else begin
      $display("** bitmap_frame_allocator: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8000000;
    $display("** bitmap_frame_allocator: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/bfa_pkg.sv
src/bfa_if.sv
src/bfa_ram.sv
src/bfa_word_op.sv
src/bitmap_frame_allocator.sv
dv/bitmap_frame_allocator_tb.sv
